// ===== hw/rtl/ascii_token_integer_parser_core_macros.svh =====
// Assertion helpers for the token parser.
`ifndef ASCII_TOKEN_INTEGER_PARSER_CORE_MACROS_SVH
`define ASCII_TOKEN_INTEGER_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define ATIP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("atip assertion failed");
// Next-cycle implication, checked outside reset.
`define ATIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("atip assertion failed");
`else
`define ATIP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ATIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/atip_pkg.sv =====
package atip_pkg;

    localparam int LINE_LENGTH = 16;
    localparam int POS_W       = $clog2(LINE_LENGTH + 1);
    localparam int CHAR_W      = 8;
    localparam int VALUE_W     = 16;
    localparam int TOKEN_W     = 4;
    localparam int RADIX_W     = 2;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [APB_ADDR_W-1:0] REG_ADDR_TOKEN_INDEX = 3'd0;

    localparam logic [RADIX_W-1:0] RADIX_DEC = 2'd0;
    localparam logic [RADIX_W-1:0] RADIX_BIN = 2'd1;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 2'd2;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_F = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LOW_X = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LOW_B = 8'h62;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef logic [CHAR_W-1:0]         t_char;
    typedef logic signed [VALUE_W-1:0] t_value;

    typedef struct packed {
        logic [VALUE_W-1:0] acc;
        logic [RADIX_W-1:0] radix;
        logic               minus;
        logic [TOKEN_W-1:0] tokens_left;
        logic               prev_zero;
        logic               prev_digit;
        logic               done;
        logic [POS_W-1:0]   pos;
    } t_line_state;

endpackage

// ===== hw/rtl/atip_if.sv =====
interface atip_in_if;
    import atip_pkg::*;

    logic  valid;
    logic  ready;
    t_char ch;
    logic  last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface atip_out_if;
    import atip_pkg::*;

    logic   valid;
    logic   ready;
    t_value value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ===== hw/rtl/atip_step.sv =====
module atip_step (
    input  atip_pkg::t_line_state        i_cur,
    input  atip_pkg::t_char              i_ch,
    input  logic                         i_last,
    input  logic [atip_pkg::TOKEN_W-1:0] i_token_index,
    output atip_pkg::t_line_state        o_next,
    output atip_pkg::t_value             o_value
);
    import atip_pkg::*;

    logic               first;
    logic               active;
    logic               is_dec;
    logic               is_hex;
    logic               is_digit;
    logic [3:0]         digit;
    logic [CHAR_W-1:0]  dec_off;
    logic [CHAR_W-1:0]  hex_off;
    logic [VALUE_W-1:0] scaled;
    logic [TOKEN_W-1:0] eff_tokens;
    t_line_state        step;

    always_comb begin
        first      = (i_cur.pos == '0);
        eff_tokens = first ? i_token_index : i_cur.tokens_left;
        active     = (i_cur.pos < POS_W'(LINE_LENGTH)) && !i_cur.done;

        is_dec   = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
        is_hex   = (i_cur.radix == RADIX_HEX) && (i_ch >= CH_LOW_A) && (i_ch <= CH_LOW_F);
        is_digit = is_dec || is_hex;
        dec_off  = i_ch - CH_ZERO;
        hex_off  = i_ch - CH_LOW_A;
        digit    = is_dec ? dec_off[3:0] : (hex_off[3:0] + 4'd10);

        // Constant-radix multiply as shifts, with one add for decimal.
        case (i_cur.radix)
            RADIX_HEX: scaled = i_cur.acc << 4;
            RADIX_BIN: scaled = i_cur.acc << 1;
            default:   scaled = (i_cur.acc << 3) + (i_cur.acc << 1);
        endcase

        step             = i_cur;
        step.tokens_left = eff_tokens;

        if (active) begin
            if (is_digit) begin
                step.acc = scaled + VALUE_W'(digit);
            end else if ((i_ch == CH_SPACE) && i_cur.prev_digit) begin
                if (eff_tokens == '0) begin
                    step.done = 1'b1;
                end else begin
                    step.tokens_left = eff_tokens - 1'b1;
                    step.acc         = '0;
                    step.radix       = RADIX_DEC;
                end
            end else if ((i_ch == CH_LOW_X) && !first && i_cur.prev_zero) begin
                step.radix = RADIX_HEX;
            end else if ((i_ch == CH_LOW_B) && !first && i_cur.prev_zero) begin
                step.radix = RADIX_BIN;
            end else if (i_ch == CH_MINUS) begin
                step.minus = 1'b1;
            end
            step.prev_digit = is_digit;
            step.prev_zero  = (i_ch == CH_ZERO);
        end

        if (i_cur.pos < POS_W'(LINE_LENGTH)) begin
            step.pos = i_cur.pos + 1'b1;
        end

        o_value = step.minus ? t_value'(-step.acc) : t_value'(step.acc);

        // Line end: drop all line state, reload the token count.
        if (i_last) begin
            o_next             = '0;
            o_next.radix       = RADIX_DEC;
            o_next.tokens_left = i_token_index;
        end else begin
            o_next = step;
        end
    end

endmodule

// ===== hw/rtl/atip_outbuf.sv =====
module atip_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  atip_pkg::t_value  i_value,
    output logic              o_can_take,
    atip_out_if.source        o_out
);
    import atip_pkg::*;

    `include "ascii_token_integer_parser_core_macros.svh"

    logic   r_out_valid;
    logic   n_out_valid;
    t_value r_out_value;
    t_value n_out_value;
    logic   r_skid_valid;
    logic   n_skid_valid;
    t_value r_skid_value;
    t_value n_skid_value;
    logic   pop;

    always_comb begin
        pop          = r_out_valid && o_out.ready;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_skid_valid = r_skid_valid;
        n_skid_value = r_skid_value;
        if (r_skid_valid) begin
            if (pop) begin
                n_out_value  = r_skid_value;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                n_out_valid = 1'b1;
                n_out_value = i_value;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_value = i_value;
            end
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_value  <= n_out_value;
        r_skid_value <= n_skid_value;
    end

    assign o_can_take  = !r_skid_valid;
    assign o_out.valid = r_out_valid;
    assign o_out.value = r_out_value;

    `ATIP_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `ATIP_ASSERT_NEXT(a_stall_to_skid, i_clk, i_rst_n,
        i_push && r_out_valid && !o_out.ready, r_skid_valid && r_out_valid)
    `ATIP_ASSERT_NEXT(a_push_shows, i_clk, i_rst_n, i_push, r_out_valid)

endmodule

// ===== hw/rtl/ascii_token_integer_parser_core.sv =====
// ASCII token integer parser.
// Characters of one command line arrive on i_in (ch, last) one request per
// cycle under valid/ready. The line is cut at spaces that follow digits; the
// token picked by token_index (APB register at byte address 0, 4 bits) is
// read as decimal, or hex/binary after a "0x"/"0b" prefix, wrapping at 16 bits.
// A '-' seen before the chosen token ends negates the result.
// On the request with last set, one signed 16-bit value leaves on o_out.
// The value is registered: it enters the output register, or the skid register
// while an earlier result still waits on o_out. One character is taken per
// cycle while the buffer has room; the per-character update (shift-add of the
// accumulator plus compares) is combinational between the line-state registers.
// Stall: results go to a two-entry buffer (output register plus skid). The
// input keeps taking characters while one result waits; ready drops only
// while both entries hold results.
// Reset (i_rst_n low at a clock edge) clears the line state, empties the
// buffer and sets token_index to 0. A token_index write applies from the
// next line on. Characters past LINE_LENGTH are ignored apart from last.
module ascii_token_integer_parser_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    atip_in_if.sink                         i_in,
    atip_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [atip_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [atip_pkg::APB_DATA_W-1:0] pwdata,
    output logic [atip_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import atip_pkg::*;

    `include "ascii_token_integer_parser_core_macros.svh"

    logic [TOKEN_W-1:0] r_token_index;
    t_line_state        r_line;
    t_line_state        n_line;
    t_value             step_value;
    logic               can_take;
    logic               accept;
    logic               reg_hit;

    // Configuration: single register, write on the access phase.
    assign pready  = 1'b1;
    assign reg_hit = (paddr == REG_ADDR_TOKEN_INDEX);
    assign prdata  = reg_hit ? APB_DATA_W'(r_token_index) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_index <= '0;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_token_index <= pwdata[TOKEN_W-1:0];
        end
    end

    // Input handshake: take a character whenever the result buffer has room.
    assign i_in.ready = can_take;
    assign accept     = i_in.valid && can_take;

    atip_step u_step (
        .i_cur         (r_line),
        .i_ch          (i_in.ch),
        .i_last        (i_in.last),
        .i_token_index (r_token_index),
        .o_next        (n_line),
        .o_value       (step_value)
    );

    // Line state advances once per accepted character. All-zero state is
    // decimal radix at position zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
        end else if (accept) begin
            r_line <= n_line;
        end
    end

    atip_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept && i_in.last),
        .i_value    (step_value),
        .o_can_take (can_take),
        .o_out      (o_out)
    );

    `ATIP_ASSERT_NEXT(a_line_cleared, i_clk, i_rst_n, accept && i_in.last,
        (r_line.pos == '0) && !r_line.done && !r_line.minus && (r_line.acc == '0))
    `ATIP_ASSERT_IMPL(a_pos_bounded, i_clk, i_rst_n, 1'b1,
        r_line.pos <= POS_W'(LINE_LENGTH))
    `ATIP_ASSERT_IMPL(a_frozen_no_digit, i_clk, i_rst_n, r_line.done, !r_line.prev_digit)

endmodule

// ===== tb/tb_ascii_token_integer_parser_core.sv =====
module tb_ascii_token_integer_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    import atip_pkg::*;

    // Line-level model of the parser. It keeps its own copy of the register
    // and the per-line state, predicts one value per line and checks the
    // values the block returns in order.
    class line_scoreboard;
        t_value             expected_q[$];
        logic [TOKEN_W-1:0] token_index;
        logic [VALUE_W-1:0] acc;
        logic [RADIX_W-1:0] radix;
        logic               minus;
        logic [TOKEN_W-1:0] tokens_left;
        t_char              prev_char;
        logic               prev_digit;
        logic               frozen;
        int                 pos;
        int                 errors;
        int                 chars_seen;
        int                 lines_seen;
        int                 values_checked;

        function new();
            token_index    = '0;
            errors         = 0;
            chars_seen     = 0;
            lines_seen     = 0;
            values_checked = 0;
            clear_line();
        endfunction

        function void clear_line();
            acc         = '0;
            radix       = RADIX_DEC;
            minus       = 1'b0;
            tokens_left = token_index;
            prev_char   = '0;
            prev_digit  = 1'b0;
            frozen      = 1'b0;
            pos         = 0;
        endfunction

        function void set_token_index(logic [TOKEN_W-1:0] idx);
            token_index = idx;
        endfunction

        // Advance the line state by one accepted character.
        function void note_request(t_char c, logic is_last);
            logic       is_digit;
            logic [4:0] digit;
            logic [4:0] base;
            chars_seen++;
            if (pos == 0)
                tokens_left = token_index;
            if (pos < LINE_LENGTH) begin
                if (!frozen) begin
                    is_digit = 1'b0;
                    digit    = '0;
                    if (c >= CH_ZERO && c <= CH_NINE) begin
                        is_digit = 1'b1;
                        digit    = 5'(c - CH_ZERO);
                    end else if (radix == RADIX_HEX && c >= CH_LOW_A && c <= CH_LOW_F) begin
                        is_digit = 1'b1;
                        digit    = 5'(c - CH_LOW_A + 10);
                    end
                    case (radix)
                        RADIX_HEX: base = 5'd16;
                        RADIX_BIN: base = 5'd2;
                        default:   base = 5'd10;
                    endcase
                    if (is_digit) begin
                        acc = acc * base + digit;
                    end else if (c == CH_SPACE && prev_digit) begin
                        if (tokens_left == 0) begin
                            frozen = 1'b1;
                        end else begin
                            tokens_left = tokens_left - 1'b1;
                            acc         = '0;
                            radix       = RADIX_DEC;
                        end
                    end else if (c == CH_LOW_X && pos != 0 && prev_char == CH_ZERO) begin
                        radix = RADIX_HEX;
                    end else if (c == CH_LOW_B && pos != 0 && prev_char == CH_ZERO) begin
                        radix = RADIX_BIN;
                    end else if (c == CH_MINUS) begin
                        minus = 1'b1;
                    end
                    prev_digit = is_digit;
                    prev_char  = c;
                end
                pos++;
            end
            if (is_last) begin
                expected_q.push_back(minus ? t_value'(16'(0) - acc) : t_value'(acc));
                lines_seen++;
                clear_line();
            end
        endfunction

        function void check_result(t_value got);
            t_value want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: value %0d returned with none expected", $time, got);
                return;
            end
            want = expected_q.pop_front();
            values_checked++;
            if (got !== want) begin
                errors++;
                $display("%0t: value mismatch, expected %0d actual %0d", $time, want, got);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    atip_in_if  in_req ();
    atip_out_if out_res ();

    line_scoreboard results;

    // Knobs shared by the driving processes; always changed with NBAs so
    // every process sees the same value at a given edge.
    logic idle_on;
    logic hold_off;

    t_char line_chars[$];
    int    settings_used;

    ascii_token_integer_parser_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_req),
        .o_out   (out_res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #4ms;
        $display("status: fail");
        $finish;
    end

    function automatic t_char hex_char(int n);
        return (n < 10) ? t_char'(CH_ZERO + n) : t_char'(CH_LOW_A + n - 10);
    endfunction

    function automatic void load_text(string s);
        line_chars.delete();
        for (int k = 0; k < s.len(); k++)
            line_chars.push_back(t_char'(s[k]));
    endfunction

    // Build one random line. Most lines are space-separated numbers with
    // optional sign and radix prefix; some are raw byte noise, some run past
    // the line length, some carry stray letters or out-of-range digits.
    function automatic void compose_line(int max_tokens);
        int               ntok;
        logic [RADIX_W-1:0] pick;
        line_chars.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 20))
                line_chars.push_back(t_char'($urandom_range(0, 255)));
            return;
        end
        ntok = $urandom_range(1, max_tokens);
        for (int t = 0; t < ntok; t++) begin
            if (t != 0) begin
                line_chars.push_back(CH_SPACE);
                if ($urandom_range(0, 7) == 0)
                    line_chars.push_back(CH_SPACE);
            end
            if ($urandom_range(0, 4) == 0)
                line_chars.push_back(CH_MINUS);
            pick = RADIX_W'($urandom_range(0, 2));
            if (pick != RADIX_DEC) begin
                line_chars.push_back(CH_ZERO);
                line_chars.push_back(pick == RADIX_HEX ? CH_LOW_X : CH_LOW_B);
            end
            repeat ($urandom_range(1, 5)) begin
                case (pick)
                    RADIX_HEX: line_chars.push_back(hex_char($urandom_range(0, 15)));
                    RADIX_BIN: line_chars.push_back(hex_char(($urandom_range(0, 7) == 0) ?
                                   $urandom_range(2, 9) : $urandom_range(0, 1)));
                    default:   line_chars.push_back(hex_char($urandom_range(0, 9)));
                endcase
                if ($urandom_range(0, 11) == 0)
                    line_chars.push_back(t_char'($urandom_range(CH_LOW_A, CH_LOW_A + 25)));
            end
        end
        if ($urandom_range(0, 3) == 0)
            line_chars.push_back(CH_SPACE);
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 12))
                line_chars.push_back(hex_char($urandom_range(0, 15)));
    endfunction

    // Offer one character and wait for it to be taken. Called at a clock
    // edge; returns at the edge that accepted the request, with valid still
    // high so the next call can keep it up without a glitch.
    task automatic send_char(t_char c, logic is_last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_req.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_req.valid <= 1'b1;
        in_req.ch    <= c;
        in_req.last  <= is_last;
        do @(posedge i_clk); while (!(in_req.valid && in_req.ready));
        results.note_request(c, is_last);
    endtask

    task automatic send_line();
        for (int k = 0; k < line_chars.size(); k++)
            send_char(line_chars[k], k == line_chars.size() - 1);
    endtask

    // Drop valid and let every pending value come back, then let the block sit
    // idle before anything touches the register.
    task automatic wait_quiet();
        in_req.valid <= 1'b0;
        while (results.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready. Upper data bits
    // carry junk to make sure only the index bits land in the register.
    task automatic write_token_index(logic [TOKEN_W-1:0] idx);
        logic [APB_DATA_W-1:0] data;
        data = $urandom;
        data[TOKEN_W-1:0] = idx;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_ADDR_TOKEN_INDEX;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        results.set_token_index(idx);
        settings_used++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Result side: check every accepted value, and stall in random bursts.
    // A long hold-off from the stimulus side overrides everything else.
    initial begin
        int stall_left;
        stall_left    = 0;
        out_res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_res.valid && out_res.ready)
                results.check_result(out_res.value);
            if (hold_off) begin
                out_res.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_res.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 9);
                out_res.ready <= 1'b0;
            end else begin
                out_res.ready <= 1'b1;
            end
        end
    end

    initial begin
        int                 phase_index [8];
        logic [TOKEN_W-1:0] cur_index;
        int                 phase_start;
        int                 max_tokens;

        results       = new();
        settings_used = 1;
        phase_index   = '{15, 1, 0, 2, -1, 3, 7, 1};

        // Hold every input at a known value through reset.
        i_rst_n       <= 1'b0;
        in_req.valid  <= 1'b0;
        in_req.ch     <= '0;
        in_req.last   <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        hold_off      <= 1'b0;
        idle_on       <= 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed lines with the reset token_index of zero.
        // Hex prefix, ending on a digit at the line end.
        load_text("0xff");
        send_line();
        // Minus before the token, then a space that freezes it on the last mark.
        load_text("-12 ");
        send_line();
        // Binary prefix.
        load_text("0b101");
        send_line();
        // Frozen token: the minus after it must be ignored.
        load_text("9 -7");
        send_line();
        // An 'x' as first character has nothing before it and stays inert.
        load_text("x");
        send_line();
        // Byte extremes are not digits and change nothing.
        line_chars.delete();
        line_chars.push_back(8'hff);
        line_chars.push_back(8'h00);
        line_chars.push_back(t_char'(CH_ZERO + 1));
        send_line();

        // Random phases, one register setting each. The final phase runs
        // without any idling on either side.
        for (int ph = 0; ph < 8; ph++) begin
            wait_quiet();
            cur_index = (phase_index[ph] < 0) ? TOKEN_W'($urandom_range(0, 15))
                                              : TOKEN_W'(phase_index[ph]);
            if (ph == 7)
                idle_on <= 1'b0;
            write_token_index(cur_index);
            max_tokens = (cur_index + 2 > 6) ? 6 : cur_index + 2;

            // Hold the result side off for a long stretch while short lines
            // keep coming, so both result slots fill and the input stalls.
            if (ph == 2) begin
                hold_off <= 1'b1;
                fork
                    begin
                        repeat (400) @(posedge i_clk);
                        hold_off <= 1'b0;
                    end
                join_none
                repeat (40) begin
                    line_chars.delete();
                    repeat ($urandom_range(1, 2))
                        line_chars.push_back(hex_char($urandom_range(0, 9)));
                    send_line();
                end
            end

            phase_start = results.chars_seen;
            while (results.chars_seen - phase_start < 200) begin
                compose_line(max_tokens);
                send_line();
            end
        end

        // Drain, then wait on for any stray value to show up.
        in_req.valid <= 1'b0;
        while (results.expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("run: %0d characters, %0d lines, %0d values checked, %0d token_index settings",
                 results.chars_seen, results.lines_seen, results.values_checked, settings_used);
        $display("run: radix prefixes, signs, noise bytes, overlong lines and a long output stall");
        if (results.errors == 0 && results.expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/atip_pkg.sv
hw/rtl/atip_if.sv
hw/rtl/atip_step.sv
hw/rtl/atip_outbuf.sv
hw/rtl/ascii_token_integer_parser_core.sv
tb/tb_ascii_token_integer_parser_core.sv
